[sv/mqsb_pkg.sv]
// Package for the shared-buffer multi-queue: field widths, command and status codes.
`default_nettype none

package mqsb_pkg;

  // Field widths of the command and result beats
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned QIDX_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // Command codes; the last code is a no-op
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ       = 2'd0,
    CMD_ENQ_SHORT = 2'd1,
    CMD_DEQ_LONG  = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

endpackage : mqsb_pkg

`default_nettype wire

[sv/mqsb_if.sv]
// Valid/ready channel interfaces for command beats and result beats.
`default_nettype none

interface mqsb_cmd_if ();
  import mqsb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [QIDX_W-1:0]         queue_index;
  logic signed [VALUE_W-1:0] value_in;

  modport source (output valid, output command, output queue_index, output value_in,
                  input ready);
  modport sink   (input valid, input command, input queue_index, input value_in,
                  output ready);
endinterface : mqsb_cmd_if

interface mqsb_res_if ();
  import mqsb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [QIDX_W-1:0]         served_queue;
  logic signed [VALUE_W-1:0] value_out;

  modport source (output valid, output status, output served_queue, output value_out,
                  input ready);
  modport sink   (input valid, input status, input served_queue, input value_out,
                  output ready);
endinterface : mqsb_res_if

`default_nettype wire

[sv/mqsb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module mqsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : mqsb_ram

`default_nettype wire

[sv/multi_queue_shared_buffer_core.sv]
// Top level: several linked FIFO queues sharing one cell store and a free list.
//
// Usage: each command beat on cmd_i enqueues value_in to a named queue, enqueues
// to the shortest queue, or dequeues from the longest queue (ties go to the
// lowest index); the fourth command code does nothing. Each command yields
// exactly one result beat on res_o with a status (ok, overflow when no cell is
// free, underflow when all queues are empty), the queue served and the
// dequeued item.
// Timing: a command is accepted in the idle state; the link state then uses the
// registered link read of the cell store and, once the output register is free,
// updates the lists and loads the result beat. Every command passes the link
// state because of the registered read port of the link RAM that each enqueue and
// dequeue must pass through before the free list and queue heads can move.
// A result waiting in the output register does not block acceptance of the
// next command; if it is still not taken when the next one finishes, that
// command holds in the link state until res_o.ready.
// Reset: all queues empty and all cells free. Cells never handed out are
// tracked by a fill count, so no clearing pass runs and commands are taken
// as soon as reset is released.
`default_nettype none

module multi_queue_shared_buffer_core #(
  parameter int unsigned QUEUES     = 4,
  parameter int unsigned CELLS      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mqsb_cmd_if.sink  cmd_i,
  mqsb_res_if.source res_o
);
  import mqsb_pkg::*;

  localparam int unsigned CW = $clog2(CELLS);
  localparam int unsigned NW = $clog2(CELLS + 1);
  localparam int unsigned QW = $clog2(QUEUES);
  localparam int unsigned QP = 1 << QW;

  typedef enum logic {
    S_IDLE,
    S_LINK
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ENQ,
    OP_DEQ
  } op_e;

  // State
  state_e          state_q;
  op_e             op_q;
  status_e         stat_q;
  logic [QW-1:0]   srv_q;
  logic [CW-1:0]   cell_q;
  logic            fresh_hit_q;
  logic            was_empty_q;
  logic [CW-1:0]   free_head_q;
  logic [NW-1:0]   free_count_q;
  logic [NW-1:0]   fresh_q;
  logic [CW-1:0]   queue_head_q  [QUEUES];
  logic [CW-1:0]   queue_tail_q  [QUEUES];
  logic [NW-1:0]   queue_count_q [QUEUES];

  logic                 res_valid_q;
  status_e              res_status_q;
  logic [QIDX_W-1:0]    res_served_q;
  logic [VALUE_W-1:0]   res_value_q;

  // Selection trees
  logic [NW-1:0] mn_cnt [2*QP];
  logic [QW-1:0] mn_idx [2*QP];
  logic [NW-1:0] mx_cnt [2*QP];
  logic [QW-1:0] mx_idx [2*QP];

  // Issue-cycle decode
  cmd_e           cmd;
  logic           accept;
  logic           is_enq;
  logic           is_deq;
  logic           enq_ok;
  logic           deq_ok;
  logic [QW-1:0]  qi_mod;
  logic [QW-1:0]  served_d;
  logic [CW-1:0]  cell_d;
  status_e        stat_d;
  op_e            op_d;

  // Link-cycle signals
  logic                  done;
  logic [CW-1:0]         next_link;
  logic [CW-1:0]         link_rdata;
  logic [DATA_WIDTH-1:0] data_rdata;
  logic [63:0]           item_ext;
  logic                  link_we;
  logic [CW-1:0]         link_waddr;
  logic [CW-1:0]         link_wdata;

  // Shortest and longest queue: pairwise trees, left side wins ties
  always_comb begin
    for (int i = 0; i < QP; i++) begin
      if (i < QUEUES) begin
        mn_cnt[QP+i] = queue_count_q[i];
        mx_cnt[QP+i] = queue_count_q[i];
      end else begin
        mn_cnt[QP+i] = '1;
        mx_cnt[QP+i] = '0;
      end
      mn_idx[QP+i] = QW'(i);
      mx_idx[QP+i] = QW'(i);
    end
    mn_cnt[0] = '0;
    mn_idx[0] = '0;
    mx_cnt[0] = '0;
    mx_idx[0] = '0;
    for (int n = QP - 1; n >= 1; n--) begin
      if (mn_cnt[2*n+1] < mn_cnt[2*n]) begin
        mn_cnt[n] = mn_cnt[2*n+1];
        mn_idx[n] = mn_idx[2*n+1];
      end else begin
        mn_cnt[n] = mn_cnt[2*n];
        mn_idx[n] = mn_idx[2*n];
      end
      if (mx_cnt[2*n+1] > mx_cnt[2*n]) begin
        mx_cnt[n] = mx_cnt[2*n+1];
        mx_idx[n] = mx_idx[2*n+1];
      end else begin
        mx_cnt[n] = mx_cnt[2*n];
        mx_idx[n] = mx_idx[2*n];
      end
    end
  end

  // Fold the named queue index into range
  always_comb begin
    if (32'(cmd_i.queue_index) >= QUEUES) begin
      qi_mod = QW'(32'(cmd_i.queue_index) - QUEUES);
    end else begin
      qi_mod = QW'(cmd_i.queue_index);
    end
  end

  // Decode the incoming command and pick queue and cell
  assign accept = cmd_i.valid && (state_q == S_IDLE);
  assign cmd    = cmd_e'(cmd_i.command);

  always_comb begin
    is_enq   = 1'b0;
    is_deq   = 1'b0;
    served_d = '0;
    case (cmd)
      CMD_ENQ: begin
        is_enq   = 1'b1;
        served_d = qi_mod;
      end
      CMD_ENQ_SHORT: begin
        is_enq   = 1'b1;
        served_d = mn_idx[1];
      end
      CMD_DEQ_LONG: begin
        is_deq   = 1'b1;
        served_d = mx_idx[1];
      end
      default: begin
        served_d = '0;
      end
    endcase
    enq_ok = is_enq && (free_count_q != '0);
    deq_ok = is_deq && (mx_cnt[1] != '0);
    cell_d = is_enq ? free_head_q : queue_head_q[served_d];
    stat_d = ST_OK;
    op_d   = OP_NONE;
    if (is_enq) begin
      if (enq_ok) begin
        op_d = OP_ENQ;
      end else begin
        stat_d = ST_OVERFLOW;
      end
    end else if (is_deq) begin
      if (deq_ok) begin
        op_d = OP_DEQ;
      end else begin
        stat_d   = ST_UNDERFLOW;
        served_d = '0;
      end
    end
  end

  // Cell store: item data and next links
  mqsb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CELLS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (accept && enq_ok),
    .waddr_i (free_head_q),
    .wdata_i (DATA_WIDTH'({32'd0, cmd_i.value_in})),
    .re_i    (accept && deq_ok),
    .raddr_i (cell_d),
    .rdata_o (data_rdata)
  );

  mqsb_ram #(
    .WIDTH (CW),
    .DEPTH (CELLS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (accept && (enq_ok || deq_ok)),
    .raddr_i (cell_d),
    .rdata_o (link_rdata)
  );

  // Link cycle: a cell never handed out links to the following index
  assign done      = (state_q == S_LINK) && (!res_valid_q || res_o.ready);
  assign next_link = fresh_hit_q ? ((cell_q == CW'(CELLS - 1)) ? '0 : cell_q + 1'b1)
                                 : link_rdata;
  assign item_ext  = 64'(signed'(data_rdata));

  // Append to the tail on enqueue, push the freed cell on dequeue
  assign link_we    = done && (((op_q == OP_ENQ) && !was_empty_q) || (op_q == OP_DEQ));
  assign link_waddr = (op_q == OP_ENQ) ? queue_tail_q[srv_q] : cell_q;
  assign link_wdata = (op_q == OP_ENQ) ? cell_q : free_head_q;

  // State and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_NONE;
      stat_q       <= ST_OK;
      srv_q        <= '0;
      cell_q       <= '0;
      fresh_hit_q  <= 1'b0;
      was_empty_q  <= 1'b0;
      free_head_q  <= '0;
      free_count_q <= NW'(CELLS);
      fresh_q      <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        queue_head_q[i]  <= '0;
        queue_tail_q[i]  <= '0;
        queue_count_q[i] <= '0;
      end
      res_valid_q  <= 1'b0;
      res_status_q <= ST_OK;
      res_served_q <= '0;
      res_value_q  <= '0;
    end else begin
      // Drop the result once taken
      if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q     <= S_LINK;
            op_q        <= op_d;
            stat_q      <= stat_d;
            srv_q       <= served_d;
            cell_q      <= cell_d;
            fresh_hit_q <= (NW'(cell_d) >= fresh_q);
            was_empty_q <= (queue_count_q[served_d] == '0);
          end
        end
        S_LINK: begin
          if (done) begin
            state_q      <= S_IDLE;
            res_valid_q  <= 1'b1;
            res_status_q <= stat_q;
            res_served_q <= QIDX_W'(srv_q);
            res_value_q  <= (op_q == OP_DEQ) ? item_ext[VALUE_W-1:0] : '0;
            case (op_q)
              OP_ENQ: begin
                free_head_q          <= next_link;
                free_count_q         <= free_count_q - 1'b1;
                if (fresh_hit_q) begin
                  fresh_q <= fresh_q + 1'b1;
                end
                if (was_empty_q) begin
                  queue_head_q[srv_q] <= cell_q;
                end
                queue_tail_q[srv_q]  <= cell_q;
                queue_count_q[srv_q] <= queue_count_q[srv_q] + 1'b1;
              end
              OP_DEQ: begin
                queue_head_q[srv_q]  <= next_link;
                queue_count_q[srv_q] <= queue_count_q[srv_q] - 1'b1;
                free_head_q          <= cell_q;
                free_count_q         <= free_count_q + 1'b1;
              end
              default: begin
                free_head_q <= free_head_q;
              end
            endcase
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_i.ready        = (state_q == S_IDLE);
  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_status_q;
  assign res_o.served_queue = res_served_q;
  assign res_o.value_out    = res_value_q;

  // Free cells never exceed the store
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q <= NW'(CELLS))
    else $error("free count above store depth");

  // Cells never handed out are always free
  a_fresh_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fresh_q <= NW'(CELLS)) && ((NW'(CELLS) - fresh_q) <= free_count_q))
    else $error("fill count inconsistent with free count");

  // Overflow only when no cell is free
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK && stat_q == ST_OVERFLOW) |-> (free_count_q == '0))
    else $error("overflow reported with free cells");

  // Underflow only when every queue is empty
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK && stat_q == ST_UNDERFLOW) |-> (mx_cnt[1] == '0))
    else $error("underflow reported with a non-empty queue");

endmodule : multi_queue_shared_buffer_core

`default_nettype wire
